// ===== sv/ars_pkg.sv =====
// Package: shared types and fixed-point constants for the atan2 pipeline.
`timescale 1ns / 1ps

package ars_pkg;

    // Fraction bits of every internal ratio
    localparam int RATIO_FRAC = 32;

    localparam logic [63:0] Q_ONE   = 64'd4294967296;
    localparam logic [63:0] Q_TAN15 = 64'd1150833018;
    localparam logic [63:0] Q_TAN30 = 64'd2479700525;
    localparam logic [63:0] Q_PI6   = 64'd2248839617;
    localparam logic [63:0] Q_INV11 = 64'd390451572;
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q_HALF  = 64'd2147483648;

    // Horner coefficients, applied after the 1/11 term
    localparam logic signed [63:0] HORNER_C [0:4] = '{
        64'sd477218588,
        -64'sd613566757,
        64'sd858993459,
        -64'sd1431655765,
        64'sd4294967296
    };

    // Angles that bypass the arithmetic
    typedef enum logic [2:0] {
        SP_NONE,
        SP_ZERO,
        SP_PI_HALF,
        SP_NEG_PI_HALF,
        SP_PI
    } spec_t;

    // Per-request side information carried down the pipe
    typedef struct packed {
        spec_t spec;
        logic  steep;
        logic  xneg;
        logic  yneg;
    } side_t;

    // Series section payload
    typedef struct packed {
        logic [31:0] tm;
        logic [31:0] t2;
        side_t       side;
        logic        red;
        logic        tneg;
    } ser_t;

endpackage

// ===== sv/atan2_range_reduced_series.sv =====
// Top level: fully pipelined four-quadrant arctangent with range reduction.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive y_value and x_value and raise start; the request is
//   taken at any rising edge where start is high and busy is low. busy stays
//   low, so a new request may be issued every cycle.
//   Result channel: done is high for exactly one cycle while angle holds the
//   result (radians, signed, ANGLE_FRAC_BITS fraction bits). Results leave in
//   request order.
//   Throughput is one request per cycle. The two 32-step restoring dividers
//   (one step per stage) set most of the latency; the series adds two stages
//   per multiply.
//   Reset clears all valid bits; requests in flight are dropped and no done
//   pulse follows. Results cannot be held off by the receiver: an angle is
//   shown for one cycle only, and the pipe never stalls.
module atan2_range_reduced_series
    import ars_pkg::*;
#(
    parameter int INPUT_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 29
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [INPUT_WIDTH-1:0]    y_value,
    input  logic signed [INPUT_WIDTH-1:0]    x_value,
    output logic                             done,
    output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

    localparam int IW  = INPUT_WIDTH;
    localparam int OW  = ANGLE_FRAC_BITS + 3;
    localparam int NS  = RATIO_FRAC;
    localparam int RSH = (ANGLE_FRAC_BITS < 32) ? 32 - ANGLE_FRAC_BITS : 0;
    localparam int LSH = (ANGLE_FRAC_BITS > 32) ? ANGLE_FRAC_BITS - 32 : 0;
    localparam logic [63:0] RND   = (64'd1 << RSH) >> 1;
    localparam int PSH  = 60 - ANGLE_FRAC_BITS;
    localparam logic [63:0] PI_O  = (PI_Q60 + ((64'd1 << PSH) >> 1)) >> PSH;
    localparam logic [63:0] PI2_O = (PI_Q60 + (64'd1 << PSH)) >> (PSH + 1);
    localparam int LAT = 2 * NS + 18;

    assign busy = 1'b0;

    // ---------------- input decode ----------------
    logic           yneg, xneg, steep, r0;
    logic [IW-1:0]  ay, ax, num, den;
    spec_t          spec;

    always_comb
    begin
        yneg  = y_value[IW-1];
        xneg  = x_value[IW-1];
        ay    = yneg ? IW'(-y_value) : IW'(y_value);
        ax    = xneg ? IW'(-x_value) : IW'(x_value);
        steep = ay > ax;
        num   = steep ? ax : ay;
        den   = steep ? ay : ax;
        r0    = num >= den;
        if (ax == '0 && ay == '0)
            spec = SP_ZERO;
        else if (ax == '0)
            spec = yneg ? SP_NEG_PI_HALF : SP_PI_HALF;
        else if (ay == '0)
            spec = xneg ? SP_PI : SP_ZERO;
        else
            spec = SP_NONE;
    end

    // ---------------- first divider: ratio ----------------
    logic [IW-1:0] d1_rem_reg  [0:NS];
    logic [IW-1:0] d1_den_reg  [0:NS];
    logic [NS:0]   d1_q_reg    [0:NS];
    side_t         d1_side_reg [0:NS];
    logic          d1_vld_reg  [0:NS];

    // Load the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_vld_reg[0] <= 1'b0;
        else
            d1_vld_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        d1_rem_reg[0]  <= r0 ? '0 : num;
        d1_den_reg[0]  <= den;
        d1_q_reg[0]    <= {{NS{1'b0}}, r0};
        d1_side_reg[0] <= '{spec: spec, steep: steep, xneg: xneg, yneg: yneg};
    end

    // One restoring step per stage
    for (genvar k = 0; k < NS; k++) begin : g_div1
        logic [IW:0] rs;
        logic        ge;
        always_comb
        begin
            rs = {d1_rem_reg[k], 1'b0};
            ge = rs >= {1'b0, d1_den_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d1_vld_reg[k+1] <= 1'b0;
            else
                d1_vld_reg[k+1] <= d1_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            d1_rem_reg[k+1]  <= ge ? IW'(rs - {1'b0, d1_den_reg[k]}) : IW'(rs);
            d1_den_reg[k+1]  <= d1_den_reg[k];
            d1_q_reg[k+1]    <= {d1_q_reg[k][NS-1:0], ge};
            d1_side_reg[k+1] <= d1_side_reg[k];
        end
    end

    // ---------------- reduction product ----------------
    logic [NS:0]   r_val;
    logic [64:0]   p_prod_reg;
    logic [31:0]   p_r_reg;
    logic [31:0]   p_dm_reg;
    logic          p_red_reg, p_tneg_reg, p_vld_reg;
    side_t         p_side_reg;

    assign r_val = d1_q_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else
            p_vld_reg <= d1_vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        p_prod_reg <= 65'(r_val * Q_TAN30[31:0]);
        p_r_reg    <= r_val[31:0];
        p_red_reg  <= {31'b0, r_val} > Q_TAN15;
        p_tneg_reg <= {31'b0, r_val} < Q_TAN30;
        p_dm_reg   <= ({31'b0, r_val} < Q_TAN30) ? 32'(Q_TAN30 - {31'b0, r_val})
                                                 : 32'({31'b0, r_val} - Q_TAN30);
        p_side_reg <= d1_side_reg[NS];
    end

    // ---------------- second divider: shifted ratio ----------------
    logic [33:0] dsum;
    logic [33:0] d2_rem_reg  [0:NS];
    logic [33:0] d2_d_reg    [0:NS];
    logic [31:0] d2_low_reg  [0:NS];
    logic [31:0] d2_q_reg    [0:NS];
    logic [31:0] d2_r_reg    [0:NS];
    logic        d2_red_reg  [0:NS];
    logic        d2_tneg_reg [0:NS];
    side_t       d2_side_reg [0:NS];
    logic        d2_vld_reg  [0:NS];

    assign dsum = 34'(Q_ONE + ((65'(p_prod_reg) + 65'(Q_HALF)) >> 32));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_vld_reg[0] <= 1'b0;
        else
            d2_vld_reg[0] <= p_vld_reg;
    end

    // Numerator is dm * 2^32 + d/2; high half is dm, low half is d/2
    always_ff @(posedge clk)
    begin
        d2_rem_reg[0]  <= {2'b0, p_dm_reg};
        d2_d_reg[0]    <= dsum;
        d2_low_reg[0]  <= dsum[32:1];
        d2_q_reg[0]    <= '0;
        d2_r_reg[0]    <= p_r_reg;
        d2_red_reg[0]  <= p_red_reg;
        d2_tneg_reg[0] <= p_tneg_reg;
        d2_side_reg[0] <= p_side_reg;
    end

    for (genvar k = 0; k < NS; k++) begin : g_div2
        logic [34:0] rs;
        logic        ge;
        always_comb
        begin
            rs = {d2_rem_reg[k], d2_low_reg[k][31]};
            ge = rs >= {1'b0, d2_d_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d2_vld_reg[k+1] <= 1'b0;
            else
                d2_vld_reg[k+1] <= d2_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            d2_rem_reg[k+1]  <= ge ? 34'(rs - {1'b0, d2_d_reg[k]}) : 34'(rs);
            d2_d_reg[k+1]    <= d2_d_reg[k];
            d2_low_reg[k+1]  <= {d2_low_reg[k][30:0], 1'b0};
            d2_q_reg[k+1]    <= {d2_q_reg[k][30:0], ge};
            d2_r_reg[k+1]    <= d2_r_reg[k];
            d2_red_reg[k+1]  <= d2_red_reg[k];
            d2_tneg_reg[k+1] <= d2_tneg_reg[k];
            d2_side_reg[k+1] <= d2_side_reg[k];
        end
    end

    // ---------------- series: t squared ----------------
    logic [31:0] tm_sel;
    logic [63:0] sq_prod_reg;
    ser_t        sq_ser_reg;
    logic        sq_vld_reg;

    assign tm_sel = d2_red_reg[NS] ? d2_q_reg[NS] : d2_r_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else
            sq_vld_reg <= d2_vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        sq_prod_reg <= 64'(tm_sel * tm_sel);
        sq_ser_reg  <= '{tm: tm_sel, t2: '0, side: d2_side_reg[NS],
                         red: d2_red_reg[NS], tneg: d2_tneg_reg[NS]};
    end

    // Horner points: h at point 0 is -1/11
    logic signed [63:0] hs_h_reg   [0:5];
    ser_t               hs_ser_reg [0:5];
    logic               hs_vld_reg [0:5];
    ser_t               hs_in;

    // Round t squared into the payload
    always_comb
    begin
        hs_in    = sq_ser_reg;
        hs_in.t2 = 32'((sq_prod_reg + Q_HALF) >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hs_vld_reg[0] <= 1'b0;
        else
            hs_vld_reg[0] <= sq_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        hs_h_reg[0]   <= -$signed(Q_INV11);
        hs_ser_reg[0] <= hs_in;
    end

    // Each step: multiply magnitude, then round, sign and add the coefficient
    for (genvar j = 0; j < 5; j++) begin : g_horner
        logic [32:0] hmag;
        logic [64:0] m_prod_reg;
        logic        m_neg_reg, m_vld_reg;
        ser_t        m_ser_reg;
        logic [64:0] rnd;
        logic signed [63:0] term;

        assign hmag = hs_h_reg[j][63] ? 33'(-hs_h_reg[j]) : 33'(hs_h_reg[j]);

        always_comb
        begin
            rnd  = (m_prod_reg + 65'(Q_HALF)) >> 32;
            term = m_neg_reg ? -$signed(64'(rnd)) : $signed(64'(rnd));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_vld_reg       <= 1'b0;
                hs_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                m_vld_reg       <= hs_vld_reg[j];
                hs_vld_reg[j+1] <= m_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            m_prod_reg      <= 65'(hs_ser_reg[j].t2 * hmag);
            m_neg_reg       <= hs_h_reg[j][63];
            m_ser_reg       <= hs_ser_reg[j];
            hs_h_reg[j+1]   <= HORNER_C[j] + term;
            hs_ser_reg[j+1] <= m_ser_reg;
        end
    end

    // ---------------- final multiply and octant angle ----------------
    logic [32:0]        fh_mag;
    logic [64:0]        f_prod_reg;
    logic               f_neg_reg, f_vld_reg;
    ser_t               f_ser_reg;
    logic [64:0]        f_rnd;
    logic signed [63:0] f_s;
    logic signed [63:0] th_reg;
    side_t              th_side_reg;
    logic               th_vld_reg;

    assign fh_mag = hs_h_reg[5][63] ? 33'(-hs_h_reg[5]) : 33'(hs_h_reg[5]);

    always_comb
    begin
        f_rnd = (f_prod_reg + 65'(Q_HALF)) >> 32;
        f_s   = f_neg_reg ? -$signed(64'(f_rnd)) : $signed(64'(f_rnd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg  <= 1'b0;
            th_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg  <= hs_vld_reg[5];
            th_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_prod_reg  <= 65'(hs_ser_reg[5].tm * fh_mag);
        f_neg_reg   <= hs_h_reg[5][63];
        f_ser_reg   <= hs_ser_reg[5];
        th_side_reg <= f_ser_reg.side;
        if (f_ser_reg.red)
            th_reg <= $signed(Q_PI6) + (f_ser_reg.tneg ? -f_s : f_s);
        else
            th_reg <= f_s;
    end

    // ---------------- output scaling, mirroring and special cases ----------------
    logic [63:0]        u_clamp;
    logic signed [63:0] ang;
    logic               done_reg, done_next;
    logic [OW-1:0]      angle_reg, angle_next;

    always_comb
    begin
        u_clamp = th_reg[63] ? '0 : 64'(th_reg);
        ang     = $signed(((u_clamp + RND) >> RSH) << LSH);
        if (th_side_reg.steep)
            ang = $signed(PI2_O) - ang;
        if (th_side_reg.xneg)
            ang = $signed(PI_O) - ang;
        if (th_side_reg.yneg)
            ang = -ang;
        unique case (th_side_reg.spec)
            SP_ZERO:        angle_next = '0;
            SP_PI_HALF:     angle_next = OW'(PI2_O);
            SP_NEG_PI_HALF: angle_next = OW'(-$signed(PI2_O));
            SP_PI:          angle_next = OW'(PI_O);
            default:        angle_next = OW'(ang);
        endcase
        done_next = th_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = $signed(angle_reg);

    // ---------------- assertions ----------------
    // Every request yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after pipeline latency");

    // Angle stays within minus pi to plus pi
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(64'(angle)) <= $signed(PI_O)
                  && $signed(64'(angle)) >= -$signed(PI_O)))
        else $error("angle outside range");

    // Remainder of the ratio divider starts below the divisor
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (d1_vld_reg[0] && d1_side_reg[0].spec == SP_NONE)
            |-> d1_rem_reg[0] < d1_den_reg[0])
        else $error("divider remainder out of range");

endmodule

// ===== tb/tb_top.sv =====
// Testbench: checks the atan2 pipeline against its own angle predictor.
`timescale 1ns / 1ps

module tb_top;
    import ars_pkg::*;

    localparam int LATENCY = 82;
    localparam longint PI_OUT   = (PI_Q60 + (64'd1 << 30)) >> 31;
    localparam longint PI_2_OUT = (PI_Q60 + (64'd1 << 31)) >> 32;

    typedef struct {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] y_value;
    logic signed [31:0] x_value;
    logic done;
    logic signed [31:0] angle;

    vec_t pending_reqs[$];
    logic [31:0] angles_due[$];
    int unsigned mismatches;
    int unsigned angles_checked;
    int unsigned reqs_sent;
    int unsigned gap_left;
    int unsigned gap_draw;

    atan2_range_reduced_series dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .y_value(y_value), .x_value(x_value), .done(done), .angle(angle)
    );

    always #10 clk = ~clk;

    // Q32 magnitude times signed Q32, rounded half up on the magnitude
    function automatic longint q32_mul(logic [63:0] a, longint b);
        logic [63:0] mb;
        logic [63:0] p;
        mb = (b < 0) ? -b : b;
        p = (a * mb + 64'h8000_0000) >> 32;
        return (b < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Odd arctangent series on a reduced Q32 magnitude
    function automatic longint atan_series(logic [63:0] tm);
        logic [63:0] t2;
        longint h;
        t2 = (tm * tm + 64'h8000_0000) >> 32;
        h = longint'(HORNER_C[0]) - q32_mul(t2, longint'(Q_INV11));
        for (int k = 1; k < 5; k++)
            h = longint'(HORNER_C[k]) + q32_mul(t2, h);
        return q32_mul(tm, h);
    endfunction

    function automatic logic [31:0] predict_angle(logic signed [31:0] y,
                                                  logic signed [31:0] x);
        logic [63:0] ay, ax, num, den, r, rem, dm, d, tm, u;
        logic steep, tneg;
        longint theta, s, ang;
        ay = (y < 0) ? -longint'(y) : longint'(y);
        ax = (x < 0) ? -longint'(x) : longint'(x);
        if (ax == 0 && ay == 0)
            ang = 0;
        else if (ax == 0)
            ang = (y < 0) ? -PI_2_OUT : PI_2_OUT;
        else if (ay == 0)
            ang = (x < 0) ? PI_OUT : 0;
        else
        begin
            steep = ay > ax;
            num = steep ? ax : ay;
            den = steep ? ay : ax;
            r = (num >= den) ? 1 : 0;
            rem = num - r * den;
            for (int i = 0; i < 32; i++)
            begin
                rem = rem << 1;
                r = r << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    r[0] = 1'b1;
                end
            end
            if (r > Q_TAN15)
            begin
                tneg = r < Q_TAN30;
                dm = tneg ? Q_TAN30 - r : r - Q_TAN30;
                d = Q_ONE + ((r * Q_TAN30 + 64'h8000_0000) >> 32);
                tm = ((dm << 32) + (d >> 1)) / d;
                s = atan_series(tm);
                theta = longint'(Q_PI6) + (tneg ? -s : s);
            end
            else
                theta = atan_series(r);
            u = (theta < 0) ? 0 : theta;
            ang = longint'((u + 4) >> 3);
            if (steep) ang = PI_2_OUT - ang;
            if (x < 0) ang = PI_OUT - ang;
            if (y < 0) ang = -ang;
        end
        return ang[31:0];
    endfunction

    // Drive requests from the pending queue, with a random gap or none between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            y_value <= '0;
            x_value <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            angles_due.push_back(predict_angle(y_value, x_value));
            reqs_sent <= reqs_sent + 1;
            gap_draw = $urandom_range(0, 5);
            if (pending_reqs.size() > 0 && gap_draw != 0)
            begin
                start <= 1'b0;
                gap_left <= gap_draw - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                y_value <= pending_reqs[0].y;
                x_value <= pending_reqs[0].x;
                void'(pending_reqs.pop_front());
            end
            else
                start <= 1'b0;
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_reqs.size() > 0)
            begin
                start <= 1'b1;
                y_value <= pending_reqs[0].y;
                x_value <= pending_reqs[0].x;
                void'(pending_reqs.pop_front());
            end
        end
    end

    // Compare each done pulse with the oldest predicted angle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected angle %0d", angle);
            end
            else
            begin
                if (angle !== angles_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("angle mismatch: expected %0d got %0d",
                                 $signed(angles_due[0]), angle);
                end
                void'(angles_due.pop_front());
                angles_checked++;
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1: return $signed(32'($urandom_range(0, 20))) - 10;
            2: return $signed($urandom) >>> $urandom_range(0, 31);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic vec_t make_vec(logic signed [31:0] y, logic signed [31:0] x);
        vec_t v;
        v.y = y;
        v.x = x;
        return v;
    endfunction

    // Fill the request queue: corners and special cases, then random vectors
    initial
    begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        clk = 0;
        rst_n = 0;
        mismatches = 0;
        angles_checked = 0;
        reqs_sent = 0;
        pending_reqs.push_back(make_vec(0, 0));
        pending_reqs.push_back(make_vec(5, 0));
        pending_reqs.push_back(make_vec(-5, 0));
        pending_reqs.push_back(make_vec(0, 7));
        pending_reqs.push_back(make_vec(0, -7));
        pending_reqs.push_back(make_vec(3, 3));
        pending_reqs.push_back(make_vec(-3, -3));
        pending_reqs.push_back(make_vec(32'sh8000_0000, 32'sh8000_0000));
        pending_reqs.push_back(make_vec(32'sh8000_0000, 32'sh7fff_ffff));
        pending_reqs.push_back(make_vec(32'sh7fff_ffff, 32'sh8000_0000));
        pending_reqs.push_back(make_vec(32'sh7fff_ffff, 32'sh7fff_ffff));
        pending_reqs.push_back(make_vec(32'sh8000_0000, 0));
        pending_reqs.push_back(make_vec(0, 32'sh8000_0000));
        pending_reqs.push_back(make_vec(1, 32'sh7fff_ffff));
        pending_reqs.push_back(make_vec(-1, 32'sh8000_0000));
        pending_reqs.push_back(make_vec(26795, 100000));
        pending_reqs.push_back(make_vec(26796, -100000));
        pending_reqs.push_back(make_vec(57735, 100000));
        pending_reqs.push_back(make_vec(-100000, 57735));
        for (int i = 0; i < 880; i++)
        begin
            a = rand_comp();
            b = rand_comp();
            pending_reqs.push_back(make_vec(a, b));
        end
        repeat (11) @(posedge clk);
        rst_n <= 1;
        wait (pending_reqs.size() == 0 && !start);
        wait (angles_due.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d vectors across all quadrants, axes and corners; %0d angles checked",
                 reqs_sent, angles_checked);
        if (mismatches == 0 && angles_due.size() == 0)
            $display("[atan2_range_reduced_series] OK");
        else
            $display("[atan2_range_reduced_series] ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("timeout");
        $display("[atan2_range_reduced_series] ERROR");
        $finish;
    end

endmodule
